FILE: hw/rtl/lcg40_uniform_range_core_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef LCG40_UNIFORM_RANGE_CORE_MACROS_SVH
`define LCG40_UNIFORM_RANGE_CORE_MACROS_SVH

// Clocked on clk, masked during rst.
`define LCGUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked while rst is high.
`define LCGUR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lcgur_pkg.sv
// Shared widths, constants and types of the ranged LCG.
package lcgur_pkg;

  localparam int StateW = 40;
  localparam int RegW   = 31;
  localparam int OutW   = 32;
  localparam int DivW   = StateW + 1;
  localparam int CntW   = $clog2(DivW);
  localparam int CfgIdxW = 2;

  localparam logic [StateW-1:0] LcgMult = 40'h4C8F53A795;

  localparam logic [CfgIdxW-1:0] CfgRangeLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeHigh = 2'd1;

  localparam logic ActDraw = 1'b0;
  localparam logic ActLoad = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/lcgur_ifs.sv
// Request and result channel interfaces of the ranged LCG.
interface lcgur_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [lcgur_pkg::StateW-1:0]  seed_value;

  modport source (output valid, action, seed_value, input ready);
  modport sink   (input valid, action, seed_value, output ready);
endinterface

interface lcgur_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lcgur_pkg::OutW-1:0]    random_value;
  logic                          range_error;

  modport source (output valid, random_value, range_error, input ready);
  modport sink   (input valid, random_value, range_error, output ready);
endinterface

FILE: hw/rtl/lcgur_div.sv
// Restoring divider, one quotient bit per cycle.
`include "lcg40_uniform_range_core_macros.svh"

module lcgur_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lcgur_pkg::DivW-1:0]    dividend,
  input  logic [lcgur_pkg::DivW-1:0]    divisor,
  output logic [lcgur_pkg::DivW-1:0]    quotient,
  output lcgur_pkg::div_stat_t          stat
);
  import lcgur_pkg::*;

  logic [DivW-1:0] rem;
  logic [DivW-1:0] quo;
  logic [DivW-1:0] dvsr;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;

  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            fits;

  always_comb begin
    trial = {rem, quo[DivW-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvsr <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit is always clear
        rem <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
        quo <= {quo[DivW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `LCGUR_ASSERT_ALWAYS(a_done_not_busy, done |-> !busy, "divider done while busy")
  `LCGUR_ASSERT(a_start_busy, start |=> busy, "divider did not start")
  `LCGUR_ASSERT(a_last_done, (busy && !start && cnt == CntW'(DivW - 1)) |=> done,
                "divider missed its last step")

endmodule

FILE: hw/rtl/lcg40_uniform_range_core.sv
// Top level of the 40-bit LCG with configurable output range.
`include "lcg40_uniform_range_core_macros.svh"

// A load request gives no result. A draw advances the state
// as state = 0x4C8F53A795*state + 1 (mod 2^40) and returns state/scale + range_low,
// scale = floor(2^40/(range_high-range_low+1)); the value may be range_high+1 or more.
// A draw's result reaches the output register as follows: a bit-serial multiplier
// runs beside the serial divider working out scale, then the same divider forms
// the quotient, which is added to range_low and registered before it is loaded
// into the output register. With range_high below range_low a draw returns 0 with
// range_error set and leaves the state alone. One request is in flight at a time;
// a finished result sits in an output register, and the next request is taken
// once the result is loaded there.
module lcg40_uniform_range_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lcgur_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [lcgur_pkg::RegW-1:0]        cfg_wdata,
  lcgur_req_if.sink                         req,
  lcgur_rsp_if.source                       rsp
);
  import lcgur_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_QUOT,
    S_FINISH
  } state_t;

  state_t            st;
  logic [StateW-1:0] gen_state;
  logic [RegW-1:0]   range_low;
  logic [RegW-1:0]   range_high;

  // serial multiplier
  logic [StateW-1:0] acc;
  logic [StateW-1:0] madd;
  logic [StateW-1:0] sreg;
  logic [CntW-1:0]   mcnt;

  logic [OutW-1:0]   res_val;
  logic              res_err;
  logic              out_vld;
  logic [OutW-1:0]   out_val;
  logic              out_err;

  logic              accept;
  logic              inverted;
  logic [OutW-1:0]   span;
  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [DivW-1:0]   div_divisor;
  logic [DivW-1:0]   div_quo;
  div_stat_t         div_stat;

  assign req.ready = (st == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign inverted  = (range_high < range_low);
  assign span      = OutW'(range_high) - OutW'(range_low) + 1'b1;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b1, {StateW{1'b0}}};
    div_divisor  = {{(DivW-OutW){1'b0}}, span};
    if (st == S_IDLE) begin
      div_start = accept && (req.action == ActDraw) && !inverted;
    end else if (st == S_SCALE) begin
      div_start    = div_stat.done;
      div_dividend = {1'b0, acc};
      div_divisor  = div_quo;
    end
  end

  lcgur_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgRangeLow:  range_low  <= cfg_wdata;
        CfgRangeHigh: range_high <= cfg_wdata;
        default: ;
      endcase
    end
    if (rst) begin
      range_low  <= RegW'(20);
      range_high <= RegW'(400);
      st         <= S_IDLE;
      gen_state  <= '0;
      mcnt       <= CntW'(StateW);
      out_vld    <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      if (mcnt != CntW'(StateW)) begin
        if (sreg[0]) begin
          acc <= acc + madd;
        end
        madd <= {madd[StateW-2:0], 1'b0};
        sreg <= {1'b0, sreg[StateW-1:1]};
        mcnt <= mcnt + 1'b1;
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            if (req.action == ActLoad) begin
              gen_state <= req.seed_value;
            end else if (inverted) begin
              res_val <= '0;
              res_err <= 1'b1;
              st      <= S_FINISH;
            end else begin
              acc  <= StateW'(1);
              madd <= LcgMult;
              sreg <= gen_state;
              mcnt <= '0;
              st   <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (div_stat.done) begin
            gen_state <= acc;
            st        <= S_QUOT;
          end
        end
        S_QUOT: begin
          if (div_stat.done) begin
            res_val <= div_quo[OutW-1:0] + OutW'(range_low);
            res_err <= 1'b0;
            st      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_vld || rsp.ready) begin
            out_vld <= 1'b1;
            out_val <= res_val;
            out_err <= res_err;
            st      <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.random_value = out_val;
  assign rsp.range_error  = out_err;

  `LCGUR_ASSERT(a_mul_before_quot, (st == S_QUOT) |-> (mcnt == CntW'(StateW)),
                "multiply unfinished when quotient starts")
  `LCGUR_ASSERT(a_start_idle_div, div_start |-> !div_stat.busy,
                "divider restarted while busy")
  `LCGUR_ASSERT(a_err_zero, (out_vld && out_err) |-> (out_val == '0),
                "range error with nonzero value")
  `LCGUR_ASSERT(a_err_keeps_state,
                (accept && req.action == ActDraw && inverted) |=> $stable(gen_state),
                "state moved on range error")

endmodule

FILE: bench/lcg40_uniform_range_core_test.sv
// Self-checking bench for the ranged 40-bit LCG core: directed table, then random range phases.
module lcg40_uniform_range_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcgur_pkg::*;

  localparam int NumPhases     = 11;
  localparam int ItemsPerPhase = 148;
  localparam int SettleCycles  = 100;
  localparam int HoldCycles    = 600;
  localparam int IdleLimit     = 5000;
  localparam int ReportLimit   = 10;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam logic [RegW-1:0]    RegMax    = {RegW{1'b1}};

  typedef struct packed {
    logic [OutW-1:0] value;
    logic            err;
  } draw_result_t;

  typedef enum logic {RowWrite, RowRequest} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] idx;
    logic               act;
    logic [StateW-1:0]  data;        // register value or seed
    bit                 typed;
    logic [OutW-1:0]    want_value;
    logic               want_err;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RegW-1:0]    cfg_wdata;

  lcgur_req_if req_ch();
  lcgur_rsp_if rsp_ch();

  lcg40_uniform_range_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5ns clk = ~clk;

  // golden copy of the generator and the range registers
  logic [StateW-1:0] lcg_state = '0;
  logic [RegW-1:0]   cfg_low   = 31'd20;
  logic [RegW-1:0]   cfg_high  = 31'd400;
  draw_result_t      pending_draws[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int error_results  = 0;
  int draws_sent     = 0;
  int loads_sent     = 0;
  int range_settings = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit hold_pending   = 1'b0;
  bit quiet          = 1'b0;

  // Returns 1 when the request yields a result.
  function automatic bit predict_request(input logic act, input logic [StateW-1:0] seed,
                                         output draw_result_t res);
    logic [63:0] span;
    logic [63:0] scale;
    logic [63:0] prod;
    logic [63:0] quot;
    res = '0;
    if (act == ActLoad) begin
      lcg_state = seed;
      return 1'b0;
    end
    if (cfg_high < cfg_low) begin
      res.err = 1'b1;
      return 1'b1;
    end
    span  = 64'(cfg_high) - 64'(cfg_low) + 64'd1;
    scale = (64'd1 << StateW) / span;
    // 64-bit wrap keeps the low 40 bits exact
    prod  = 64'(LcgMult) * 64'(lcg_state) + 64'd1;
    lcg_state = prod[StateW-1:0];
    quot  = 64'(lcg_state) / scale + 64'(cfg_low);
    res.value = quot[OutW-1:0];
    return 1'b1;
  endfunction

  function automatic plan_row_t write_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [RegW-1:0] value);
    plan_row_t r;
    r = '{kind: RowWrite, default: '0};
    r.idx  = idx;
    r.data[RegW-1:0] = value;
    return r;
  endfunction

  function automatic plan_row_t request_row(input logic act, input logic [StateW-1:0] seed,
                                            input bit typed, input logic [OutW-1:0] value,
                                            input logic err);
    plan_row_t r;
    r = '{kind: RowRequest, default: '0};
    r.act        = act;
    r.data       = seed;
    r.typed      = typed;
    r.want_value = value;
    r.want_err   = err;
    return r;
  endfunction

  // Offers one request in the burst/gap pattern; returns with valid still high.
  task automatic send_request(input logic act, input logic [StateW-1:0] seed,
                              input bit typed, input draw_result_t want);
    draw_result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    quiet = 1'b0;
    if (predict_request(act, seed, res))
      pending_draws.push_back(typed ? want : res);
    if (act == ActLoad) loads_sent++;
    else draws_sent++;
  endtask

  // Register writes only once the core has drained.
  task automatic write_range_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] value);
    req_ch.valid <= 1'b0;
    if (!quiet) begin
      @(posedge clk);
      while (pending_draws.size() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
      quiet = 1'b1;
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CfgRangeLow) cfg_low = value;
    else if (idx == CfgRangeHigh) cfg_high = value;
  endtask

  initial begin : stimulus
    plan_row_t         plan[$];
    draw_result_t      want;
    draw_result_t      none;
    logic [63:0]       inv;
    logic [63:0]       tmp;
    logic [StateW-1:0] seed_top;
    logic [StateW-1:0] seed_zero;
    logic [StateW-1:0] seed;
    logic [RegW-1:0]   lo;
    logic [RegW-1:0]   hi;
    logic              act;

    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= CfgRangeLow;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ActDraw;
    req_ch.seed_value <= '0;
    none = '0;

    // seeds whose next state is all ones / zero, via the multiplier's inverse
    inv = 64'(LcgMult);
    repeat (5) inv = inv * (64'd2 - 64'(LcgMult) * inv);
    tmp = 64'd0 - inv;
    seed_zero = tmp[StateW-1:0];
    tmp = 64'd0 - (inv << 1);
    seed_top = tmp[StateW-1:0];

    // reset values: state 0 steps to 1, far below one scale step
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd20, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b0, '0, 1'b0));
    // full range
    plan.push_back(write_row(CfgRangeLow, '0));
    plan.push_back(write_row(CfgRangeHigh, RegMax));
    plan.push_back(request_row(ActLoad, seed_top, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(request_row(ActLoad, seed_zero, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd0, 1'b0));
    plan.push_back(request_row(ActLoad, 40'hFF_FFFF_FFFF, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActLoad, 40'h80_0000_0000, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b0, '0, 1'b0));
    // span of 3 at the top: all-ones state lands one past range_high
    plan.push_back(write_row(CfgRangeLow, RegMax - 31'd2));
    plan.push_back(request_row(ActLoad, seed_top, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'h8000_0000, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b0, '0, 1'b0));
    // single-value ranges
    plan.push_back(write_row(CfgRangeLow, RegMax));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(write_row(CfgRangeLow, '0));
    plan.push_back(write_row(CfgRangeHigh, '0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd0, 1'b0));
    // inverted range, state must hold across error draws
    plan.push_back(write_row(CfgRangeHigh, 31'd5));
    plan.push_back(write_row(CfgRangeLow, 31'd9));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd0, 1'b1));
    plan.push_back(request_row(ActLoad, 40'h55_5555_5555, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd0, 1'b1));
    plan.push_back(write_row(CfgSpareA, RegMax));
    plan.push_back(write_row(CfgSpareB, '0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd0, 1'b1));
    plan.push_back(write_row(CfgRangeLow, 31'd100));
    plan.push_back(write_row(CfgRangeHigh, 31'd102));
    plan.push_back(request_row(ActDraw, '0, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActLoad, seed_top, 1'b0, '0, 1'b0));
    plan.push_back(request_row(ActDraw, '0, 1'b1, 32'd103, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        write_range_reg(plan[i].idx, plan[i].data[RegW-1:0]);
      end else begin
        want.value = plan[i].want_value;
        want.err   = plan[i].want_err;
        send_request(plan[i].act, plan[i].data, plan[i].typed, want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      lo = RegW'($urandom);
      hi = RegW'($urandom);
      case (ph % 6)
        0: hi = (lo > RegMax - 31'd4000) ? RegMax : lo + RegW'($urandom_range(0, 4000));
        1: ;
        2: begin
          lo = '0;
          hi = RegMax;
        end
        3: hi = lo;
        4: begin
          lo = lo | 31'd1;
          hi = hi % lo;
        end
        default: begin
          hi = RegMax;
          if ($urandom_range(0, 1)) lo = RegMax - RegW'($urandom_range(0, 64));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_range_reg(CfgRangeLow, lo);
        write_range_reg(CfgRangeHigh, hi);
      end else begin
        write_range_reg(CfgRangeHigh, hi);
        write_range_reg(CfgRangeLow, lo);
      end
      if ($urandom_range(0, 2) == 0)
        write_range_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, RegW'($urandom));
      range_settings++;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // long receiver hold-off while requests keep coming
        if (n == 30 && (ph == 1 || ph == 7)) hold_pending = 1'b1;
        act = ($urandom_range(0, 3) == 0) ? ActLoad : ActDraw;
        case ($urandom_range(0, 15))
          0:       seed = seed_top;
          1:       seed = seed_zero;
          default: seed = {8'($urandom), 32'($urandom)};
        endcase
        send_request(act, seed, 1'b0, none);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("summary: %0d draws and %0d seed loads sent, %0d results checked (%0d range errors)",
             draws_sent, loads_sent, results_seen, error_results);
    $display("summary: directed table plus %0d random range settings, %0d mismatches",
             range_settings, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : receiver
    int mode;
    int left;
    int period;
    int hold;
    mode   = 0;
    left   = 0;
    period = 2;
    hold   = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode   = $urandom_range(0, 3);
          left   = $urandom_range(40, 400);
          period = $urandom_range(2, 7);
        end
        left--;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 15) != 0);
          default: rsp_ch.ready <= (left % period == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    draw_result_t exp_res;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (rsp_ch.range_error) error_results++;
        if (pending_draws.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result: value %0h err %0b",
                     rsp_ch.random_value, rsp_ch.range_error);
        end else begin
          exp_res = pending_draws.pop_front();
          if (rsp_ch.random_value !== exp_res.value || rsp_ch.range_error !== exp_res.err) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("result %0d: expected value %0h err %0b, got value %0h err %0b",
                       results_seen, exp_res.value, exp_res.err,
                       rsp_ch.random_value, rsp_ch.range_error);
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no request or result for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_draws.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
